// ===== hw/rtl/rld_pkg.sv =====
`timescale 1ns / 1ps
package rld_pkg;

   localparam int RUN_DEPTH = 1024;
   localparam int IDX_W     = $clog2(RUN_DEPTH);
   localparam int HELD_W    = $clog2(RUN_DEPTH + 1);
   localparam int VALUE_W   = 16;
   localparam int AMOUNT_W  = 16;
   localparam int TOTAL_W   = 32;
   localparam int ENTRY_W   = VALUE_W + AMOUNT_W;

   localparam logic KIND_TOTAL = 1'b0;
   localparam logic KIND_FRONT = 1'b1;

   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [HELD_W-1:0]   held_type;
   typedef logic [VALUE_W-1:0]  value_type;
   typedef logic [AMOUNT_W-1:0] amount_type;
   typedef logic [TOTAL_W-1:0]  total_type;

   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_DELETE  = 2'd1,
      OP_REVERSE = 2'd2
   } op_type;

   typedef struct packed {
      op_type     op;
      value_type  value;
      amount_type amount;
   } cmd_type;

   typedef struct packed {
      logic      kind;
      total_type value;
      logic      dropped;
   } rsp_type;

   function automatic idx_type slot_next(input idx_type i);
      return (i == idx_type'(RUN_DEPTH - 1)) ? '0 : i + idx_type'(1);
   endfunction

   function automatic idx_type slot_prev(input idx_type i);
      return (i == '0) ? idx_type'(RUN_DEPTH - 1) : i - idx_type'(1);
   endfunction

endpackage

// ===== hw/rtl/rld_ram.sv =====
`timescale 1ns / 1ps
module rld_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rld_front.sv =====
`timescale 1ns / 1ps
module rld_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [1:0]       req_mode,
   input  logic [15:0]      req_item_value,
   input  logic [15:0]      req_amount,
   output logic             cmd_valid,
   output rld_pkg::cmd_type cmd,
   input  logic             cmd_pop
);
   import rld_pkg::*;

   cmd_type    slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       keep;
   logic       wr;
   logic       rd;

   // mode three is taken and discarded
   always_comb begin
      unique case (req_mode) inside
         OP_ADD, OP_DELETE, OP_REVERSE: keep = 1'b1;
         default:                       keep = 1'b0;
      endcase
   end

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign wr        = req_push && !req_full && keep;
   assign rd        = cmd_pop && cmd_valid;

   always_comb begin
      count_in  = count_ff + {1'b0, wr} - {1'b0, rd};
      wr_ptr_in = wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd ? !rd_ptr_ff : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         slot_ff[wr_ptr_ff] <= '{op: op_type'(req_mode), value: req_item_value,
                                 amount: req_amount};
      end
   end

endmodule

// ===== hw/rtl/rld_rsp_queue.sv =====
`timescale 1ns / 1ps
module rld_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rld_pkg::rsp_type push_data,
   output logic             room,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rld_pkg::rsp_type head
);
   import rld_pkg::*;

   rsp_type    slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       rd;

   assign room      = (count_ff != 2'd2);
   assign rsp_empty = (count_ff == 2'd0);
   assign head      = slot_ff[rd_ptr_ff];
   assign rd        = rsp_pop && !rsp_empty;

   always_comb begin
      count_in  = count_ff + {1'b0, push} - {1'b0, rd};
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd ? !rd_ptr_ff : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/rld_back.sv =====
`timescale 1ns / 1ps
module rld_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  rld_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic             rsp_room,
   output logic             rsp_push,
   output rld_pkg::rsp_type rsp_data
);
   import rld_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type  state_ff, state_in;
   idx_type    front_ff, front_in;
   idx_type    back_ff, back_in;
   held_type   held_ff, held_in;
   total_type  total_ff, total_in;
   logic       reversed_ff, reversed_in;
   amount_type left_ff, left_in;
   idx_type    slot_ff, slot_in;
   logic       first_ff, first_in;

   logic                 wr_en;
   idx_type              wr_addr;
   logic [ENTRY_W-1:0]   wr_data;
   idx_type              rd_addr;
   logic [ENTRY_W-1:0]   rd_data;
   amount_type           cnt;
   value_type            val;
   logic [TOTAL_W:0]     sum;
   logic                 dropped;
   idx_type              add_slot;
   idx_type              next_slot;

   rld_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RUN_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cnt     = rd_data[AMOUNT_W-1:0];
   assign val     = rd_data[ENTRY_W-1:AMOUNT_W];
   assign sum     = {1'b0, total_ff} + (TOTAL_W + 1)'(cmd.amount);
   assign dropped = (held_ff == held_type'(RUN_DEPTH));

   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      back_in     = back_ff;
      held_in     = held_ff;
      total_in    = total_ff;
      reversed_in = reversed_ff;
      left_in     = left_ff;
      slot_in     = slot_ff;
      first_in    = first_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      rsp_data    = '0;
      wr_en       = 1'b0;
      wr_addr     = slot_ff;
      wr_data     = '0;
      rd_addr     = '0;
      add_slot    = reversed_ff ? slot_prev(front_ff) : back_ff;
      next_slot   = reversed_ff ? slot_prev(slot_ff) : slot_next(slot_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && rsp_room) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  OP_ADD: begin
                     if (!dropped) begin
                        if (reversed_ff) begin
                           front_in = add_slot;
                        end else begin
                           back_in = slot_next(back_ff);
                        end
                        wr_en    = 1'b1;
                        wr_addr  = add_slot;
                        wr_data  = {cmd.value, cmd.amount};
                        held_in  = held_ff + held_type'(1);
                        total_in = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                     end
                     rsp_push = 1'b1;
                     rsp_data = '{kind: KIND_TOTAL, value: total_in, dropped: dropped};
                  end
                  OP_DELETE: begin
                     total_in = (total_ff > TOTAL_W'(cmd.amount))
                              ? total_ff - TOTAL_W'(cmd.amount) : '0;
                     if (held_ff != '0) begin
                        rd_addr  = reversed_ff ? slot_prev(back_ff) : front_ff;
                        slot_in  = rd_addr;
                        left_in  = cmd.amount;
                        first_in = 1'b1;
                        state_in = ST_WALK;
                     end
                  end
                  OP_REVERSE: begin
                     reversed_in = !reversed_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            first_in = 1'b0;
            if (first_ff) begin
               rsp_push = 1'b1;
               rsp_data = '{kind: KIND_FRONT, value: TOTAL_W'(val), dropped: 1'b0};
            end
            if (left_ff == '0) begin
               state_in = ST_IDLE;
            end else if (cnt > left_ff) begin
               // trim a partly consumed run
               wr_en    = 1'b1;
               wr_addr  = slot_ff;
               wr_data  = {val, cnt - left_ff};
               state_in = ST_IDLE;
            end else begin
               left_in = left_ff - cnt;
               held_in = held_ff - held_type'(1);
               if (reversed_ff) begin
                  back_in = slot_ff;
               end else begin
                  front_in = next_slot;
               end
               rd_addr = next_slot;
               slot_in = next_slot;
               if (left_in == '0 || held_in == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         front_ff    <= '0;
         back_ff     <= '0;
         held_ff     <= '0;
         total_ff    <= '0;
         reversed_ff <= 1'b0;
         left_ff     <= '0;
         slot_ff     <= '0;
         first_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         front_ff    <= front_in;
         back_ff     <= back_in;
         held_ff     <= held_in;
         total_ff    <= total_in;
         reversed_ff <= reversed_in;
         left_ff     <= left_in;
         slot_ff     <= slot_in;
         first_ff    <= first_in;
      end
   end

endmodule

// ===== hw/rtl/run_length_deque_core.sv =====
`timescale 1ns / 1ps
// Run-length deque: stores runs of (value, repeat count) in a 1024-entry RAM.
// Input queue: drive req_mode, req_item_value, req_amount and raise req_push;
// the item is taken on a clock edge where req_full is low. Mode 0 adds a run,
// mode 1 deletes elements, mode 2 reverses direction, mode 3 is discarded.
// Result queue: while rsp_empty is low the oldest result sits on rsp_result_kind,
// rsp_result_value and rsp_add_dropped; raise rsp_pop to take it.
// An add gives one result (the running total, add_dropped set when the store
// is full). A delete gives the front run's value if any run is held. A reverse
// gives none.
// Flow: an add's total enters the result queue when the engine takes the
// command, a delete's front value after the RAM read of the front run. Add
// and reverse are handled on taking the command; a delete then walks the runs
// (one RAM read each, at least one when a run is held), and the engine takes
// no new command until the walk ends.
// A 2-entry command queue and a 2-entry result queue decouple the sides: a
// stalled receiver fills the result queue, then the engine waits, then req_full
// rises. Reset clears indices, run count, total and direction; the RAM is not
// cleared and needs no clearing pass.
module run_length_deque_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_item_value,
   input  logic [15:0] req_amount,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_result_kind,
   output logic [31:0] rsp_result_value,
   output logic        rsp_add_dropped
);
   import rld_pkg::*;

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;
   logic    rsp_room;
   logic    rsp_push;
   rsp_type rsp_data;
   rsp_type head;

   rld_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_mode       (req_mode),
      .req_item_value (req_item_value),
      .req_amount     (req_amount),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   rld_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_room  (rsp_room),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data)
   );

   rld_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .room      (rsp_room),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .head      (head)
   );

   assign rsp_result_kind  = head.kind;
   assign rsp_result_value = head.value;
   assign rsp_add_dropped  = head.dropped;

endmodule
